@@ rtl/core/rsop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsop_pkg
// Shared constants and elaboration-time helpers for the slope/offset/power
// grade core.
// ----------------------------------------------------------------------------
package rsop_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned GRADE_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd4;

  localparam logic [GRADE_W-1:0] GRADE_RESET = 48'h1000_0000_4000;
  localparam logic [15:0]        POWER_ONE   = 16'h1000;

  // Number of lane stages from input register to lane result register.
  localparam int unsigned LANE_LAT = 41;

  // Floor square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xx;
    logic [63:0] r;
    logic [63:0] b;
    xx = x;
    r  = 64'd0;
    b  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > xx) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (xx >= r + b) begin
          xx = xx - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, built by repeated square roots from 2^31.
  function automatic logic [31:0] exp_tab(input int k);
    logic [63:0] t;
    t = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      t = isqrt64(t << 30);
    end
    return t[31:0];
  endfunction

endpackage

@@ rtl/core/rgb_slope_offset_power_grade_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_slope_offset_power_grade_core
// Slope / offset / power colour grade of an RGBA pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per beat, tdata = red, green, blue, alpha (lowest up).
//   out_* : one graded pixel per beat, tdata = red, green, blue, alpha,
//           then the three clip flags.
//   cfg_* : register write port, taken on any cycle cfg_we is high; write
//           only while no pixel is in flight.
// Three identical lanes grade red, green and blue side by side; alpha and
// valid travel on a matching delay line and the merge stage packs the beat.
// The path from input beat to output beat is 41 lane stages (16 of them
// squaring steps of the log, 16 table products of the exp) plus the
// output register. Throughput is one pixel per cycle while the output is not stalled.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// in_tready drops; it resumes without loss once the beat is taken.
// Reset clears the valid line and loads grading off, three bands, and unit
// slope, zero offset and unit power on all channels.
// ----------------------------------------------------------------------------
module rgb_slope_offset_power_grade_core
  import rsop_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [((4*PIXEL_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red_out, green_out, blue_out, alpha_out, clip_flags
  output logic [((4*PIXEL_BITS+10)/8)*8-1:0] out_tdata,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [GRADE_W-1:0]                 cfg_wdata
);

  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned OW = ((4*PIXEL_BITS+10)/8)*8;

  logic               grade_enable_r;
  logic [1:0]         color_bands_r;
  logic [GRADE_W-1:0] grade_r [3];

  logic               en;
  logic               vld_r [1:LANE_LAT];
  logic [PB-1:0]      alp_r [1:LANE_LAT];
  logic [PB-1:0]      lane_y [3];
  logic [2:0]         lane_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grade_enable_r <= 1'b0;
      color_bands_r  <= 2'd3;
      grade_r[0]     <= GRADE_RESET;
      grade_r[1]     <= GRADE_RESET;
      grade_r[2]     <= GRADE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: grade_enable_r <= cfg_wdata[0];
        CFG_BANDS:  color_bands_r  <= cfg_wdata[1:0];
        CFG_RED:    grade_r[0]     <= cfg_wdata;
        CFG_GREEN:  grade_r[1]     <= cfg_wdata;
        CFG_BLUE:   grade_r[2]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LANE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int i = 2; i <= LANE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alp_r[1] <= in_tdata[4*PB-1:3*PB];
      for (int i = 2; i <= LANE_LAT; i++) alp_r[i] <= alp_r[i-1];
    end
  end

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_lane
      logic [1:0] cidx;
      assign cidx = 2'(c);
      rsop_lane #(.PB(PB)) u_lane (
        .clk      (clk),
        .en       (en),
        .grade_on (grade_enable_r && (color_bands_r > cidx)),
        .x        (in_tdata[c*PB +: PB]),
        .slope    (grade_r[c][15:0]),
        .offset   (grade_r[c][31:16]),
        .power    (grade_r[c][47:32]),
        .y        (lane_y[c]),
        .clip     (lane_clip[c])
      );
    end
  endgenerate

  rsop_merge #(.PB(PB), .OW(OW)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld        (vld_r[LANE_LAT]),
    .red        (lane_y[0]),
    .green      (lane_y[1]),
    .blue       (lane_y[2]),
    .alpha      (alp_r[LANE_LAT]),
    .clip       (lane_clip),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  localparam logic [PB-1:0] PMAX_P = PB'((32'd1 << PB) - 32'd1);

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted beat not entered in valid line");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[LANE_LAT]) && $stable(vld_r[1]))
    else $error("valid line moved during stall");

  a_no_clip_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !grade_enable_r |-> out_tdata[4*PB+2:4*PB] == 3'd0)
    else $error("clip flag raised with grading off");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4*PB] |-> out_tdata[PB-1:0] == PMAX_P)
    else $error("red clip without saturated value");
`endif

endmodule

@@ rtl/core/rsop_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsop_lane
// One colour channel: slope and offset, log2 by squaring, power multiply,
// exp2 by table products, rescale and saturate. Fully pipelined.
// ----------------------------------------------------------------------------
module rsop_lane
  import rsop_pkg::*;
#(
  parameter int unsigned PB = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic          grade_on,
  input  logic [PB-1:0] x,
  input  logic [15:0]   slope,
  input  logic [15:0]   offset,
  input  logic [15:0]   power,
  output logic [PB-1:0] y,
  output logic          clip
);

  localparam logic [16:0] PMAX  = 17'((32'd1 << PB) - 32'd1);
  localparam logic [17:0] DIV   = {PMAX, 1'b0};
  localparam int unsigned NB    = PB + 18;
  localparam int unsigned RW    = 19;
  localparam logic [63:0] RECIP = ((64'd1 << NB) + 64'(DIV) - 64'd1) / 64'(DIV);

  typedef struct packed {
    logic          grade;
    logic [PB-1:0] x;
  } side_t;

  typedef struct packed {
    logic        fast;
    logic [19:0] fy;
  } fast_t;

  typedef struct packed {
    logic signed [9:0] ip;
    logic [15:0]       f;
  } zf_t;

  side_t          sd_r [1:40];
  fast_t          fst_r [6:40];
  logic [30:0]    m_r [5:21];
  logic [15:0]    frac_r [5:21];
  logic [4:0]     e_r [5:21];
  logic [30:0]    r_r [23:39];
  zf_t            zf_r [23:39];

  logic [PB+15:0] p1_r;
  logic [NB-1:0]  n2_r, n3_r;
  logic [16:0]    qe2_r, qe3_r;
  logic [34:0]    qd3_r;
  logic [16:0]    v4_r;
  logic           fast5_r, one5_r;
  logic [19:0]    fy5_r;
  logic [32:0]    pv5_r;
  logic [36:0]    mag22_r;
  logic           neg22_r;
  logic [47:0]    qq40_r;
  logic signed [9:0] ip40_r;
  logic [PB-1:0]  y_r;
  logic           clip_r;

  // stage 2: reciprocal estimate of the rounded quotient
  logic [NB-1:0]    n2;
  logic [NB+RW-1:0] qm2;
  assign n2  = NB'({p1_r, 1'b0}) + NB'(PMAX);
  assign qm2 = (NB+RW)'(n2) * (NB+RW)'(RECIP[RW-1:0]);

  // stage 4: correct estimate, add offset, clamp at zero
  logic [16:0]        q4;
  logic signed [17:0] sv4;
  assign q4  = qe3_r - 17'(qd3_r > 35'(n3_r));
  assign sv4 = signed'({1'b0, q4}) + 18'(signed'(offset));

  // stage 5: normalize for the log
  logic [4:0] e5;
  always_comb begin
    e5 = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v4_r[i]) e5 = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1]   <= '{grade: grade_on, x: x};
      p1_r      <= (PB+16)'(x) * (PB+16)'(slope);
      n2_r      <= n2;
      qe2_r     <= qm2[NB+16:NB];
      n3_r      <= n2_r;
      qe3_r     <= qe2_r;
      qd3_r     <= 35'(qe2_r) * 35'(DIV);
      v4_r      <= sv4[17] ? 17'd0 : sv4[16:0];
      e_r[5]    <= e5;
      m_r[5]    <= 31'(v4_r) << (5'd30 - e5);
      frac_r[5] <= 16'd0;
      fast5_r   <= (power == 16'd0) || (v4_r == 17'd0) || (power == POWER_ONE);
      one5_r    <= (power == POWER_ONE) && (v4_r != 17'd0);
      fy5_r     <= (power == 16'd0) ? 20'(PMAX) : 20'd0;
      pv5_r     <= 33'(v4_r) * 33'(PMAX);
      fst_r[6]  <= '{fast: fast5_r,
                     fy: one5_r ? 20'((pv5_r + 33'd8192) >> 14) : fy5_r};
    end
  end

  genvar s;
  generate
    for (s = 2; s <= 40; s++) begin : g_side
      always_ff @(posedge clk) begin
        if (en) sd_r[s] <= sd_r[s-1];
      end
    end
    for (s = 7; s <= 40; s++) begin : g_fast
      always_ff @(posedge clk) begin
        if (en) fst_r[s] <= fst_r[s-1];
      end
    end
    // log2 fraction: one squaring per stage
    for (s = 6; s <= 21; s++) begin : g_log
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = 62'(m_r[s-1]) * 62'(m_r[s-1]);
      assign t  = sq[61:30];
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[s]    <= t[31] ? t[31:1] : t[30:0];
          frac_r[s] <= {frac_r[s-1][14:0], t[31]};
          e_r[s]    <= e_r[s-1];
        end
      end
    end
    // exp2 fraction: one table product per stage, weight 2^-k
    for (s = 24; s <= 39; s++) begin : g_exp
      localparam int K = s - 23;
      localparam logic [31:0] TK = exp_tab(K);
      logic [61:0] pr;
      assign pr = 62'(r_r[s-1]) * 62'(TK);
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[s]  <= zf_r[s-1].f[16-K] ? pr[60:30] : r_r[s-1];
          zf_r[s] <= zf_r[s-1];
        end
      end
    end
  endgenerate

  // stage 22: log times power
  logic signed [5:0]  el22;
  logic signed [21:0] lg22;
  logic [20:0]        ab22;
  assign el22 = signed'({1'b0, e_r[21]}) - 6'sd14;
  assign lg22 = {el22, frac_r[21]};
  assign ab22 = lg22[21] ? 21'(-lg22) : 21'(lg22);

  // stage 23: round, split into integer and fraction
  logic [36:0]        mr23s;
  logic [24:0]        mr23;
  logic signed [25:0] z23;
  assign mr23s = mag22_r + 37'd2048;
  assign mr23  = mr23s[36:12];
  assign z23   = neg22_r ? -signed'({1'b0, mr23}) : signed'({1'b0, mr23});

  // stage 41: rescale with rounding shift, saturate
  logic signed [10:0] sh41;
  logic [5:0]         shb;
  logic [63:0]        yexp, yraw;
  logic               clip41;
  always_comb begin
    sh41 = 11'sd30 - 11'(ip40_r);
    shb  = sh41[5:0];
    if (ip40_r >= 10'sd30) begin
      yexp = 64'(PMAX) + 64'd1;
    end else if (sh41 >= 11'sd63) begin
      yexp = 64'd0;
    end else begin
      yexp = (64'(qq40_r) + (64'd1 << (shb - 6'd1))) >> shb;
    end
    yraw   = fst_r[40].fast ? 64'(fst_r[40].fy) : yexp;
    clip41 = yraw > 64'(PMAX);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag22_r  <= 37'(ab22) * 37'(power);
      neg22_r  <= lg22[21];
      zf_r[23] <= '{ip: z23[25:16], f: z23[15:0]};
      r_r[23]  <= 31'h4000_0000;
      qq40_r   <= 48'(r_r[39]) * 48'(PMAX);
      ip40_r   <= zf_r[39].ip;
      if (sd_r[40].grade) begin
        y_r    <= clip41 ? PMAX[PB-1:0] : yraw[PB-1:0];
        clip_r <= clip41;
      end else begin
        y_r    <= sd_r[40].x;
        clip_r <= 1'b0;
      end
    end
  end

  assign y    = y_r;
  assign clip = clip_r;

endmodule

@@ rtl/core/rsop_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsop_merge
// Joins the three lane results and alpha into one output beat and holds it
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module rsop_merge
  import rsop_pkg::*;
#(
  parameter int unsigned PB = 8,
  parameter int unsigned OW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld,
  input  logic [PB-1:0] red,
  input  logic [PB-1:0] green,
  input  logic [PB-1:0] blue,
  input  logic [PB-1:0] alpha,
  input  logic [2:0]    clip,
  output logic          en,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [OW-1:0] out_tdata
);

  logic          out_tvalid_r;
  logic [OW-1:0] out_tdata_r;

  assign en = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_tdata_r <= OW'({clip, alpha, blue, green, red});
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ bench/rgb_slope_offset_power_grade_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_slope_offset_power_grade_core_test
// Drives RGBA beats through the slope/offset/power grade core under random
// stalls on both sides. Each pixel is graded by a local fixed-point model of
// the grade and checked field by field against the output beats, across
// several register settings.
// ----------------------------------------------------------------------------
module rgb_slope_offset_power_grade_core_test;
  import rsop_pkg::*;

  localparam int unsigned PMAX = 255;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0] clip;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_out_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;   // red_in, green_in, blue_in, alpha_in
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;  // red_out, green_out, blue_out, alpha_out, clip_flags
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GRADE_W-1:0] cfg_wdata;

  logic grade_on;
  logic [1:0] band_count;
  logic [47:0] chan_grade [3];
  logic [63:0] exp_steps [17];

  pixel_out_t graded_queue[$];
  int failures;
  int cycle_count;
  bit in_idle_on;
  bit out_idle_on;
  int hold_off;
  bit long_hold;
  event long_hold_ev;

  rgb_slope_offset_power_grade_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Grade one sample; bit 8 of the result carries the clip flag.
  function automatic logic [8:0] grade_one(input logic [7:0] x, input logic [47:0] g);
    logic [63:0] slope, pw, vv, m, frac, mag, f, r, q, y;
    longint off, v, lg, z, ip;
    int e, s;
    bit neg;
    slope = g[15:0];
    off = $signed(g[31:16]);
    pw = g[47:32];
    v = longint'((2 * 64'(x) * slope + PMAX) / (2 * PMAX)) + off;
    if (v < 0) v = 0;
    if (pw == 0) begin
      y = PMAX;
    end else if (v == 0) begin
      y = 0;
    end else if (pw == 64'(POWER_ONE)) begin
      y = (64'(v) * PMAX + 8192) >> 14;
    end else begin
      vv = v;
      e = 0;
      while (e < 62 && (vv >> (e + 1)) != 0) e++;
      m = vv << (30 - e);
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      lg = longint'(e - 14) * 65536 + longint'(frac);
      neg = lg < 0;
      mag = 64'(neg ? -lg : lg) * pw;
      mag = (mag + 2048) >> 12;
      z = neg ? -longint'(mag) : longint'(mag);
      if (z >= 0) ip = longint'(64'(z) >> 16);
      else ip = -longint'((mag + 65535) >> 16);
      f = 64'(z - ip * 65536);
      r = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if (f[16-k]) r = (r * exp_steps[k]) >> 30;
      q = r * PMAX;
      if (ip >= 30) begin
        y = PMAX + 1;
      end else if (30 - ip >= 63) begin
        y = 0;
      end else begin
        s = 30 - ip;
        y = (q + (64'd1 << (s - 1))) >> s;
      end
    end
    if (y > PMAX) return {1'b1, 8'hFF};
    return {1'b0, y[7:0]};
  endfunction

  function automatic pixel_out_t grade_pixel(input logic [31:0] px);
    pixel_out_t o;
    logic [8:0] g;
    logic [7:0] chan [3];
    o.clip = 0;
    for (int c = 0; c < 3; c++) begin
      chan[c] = px[8*c +: 8];
      if (grade_on && c < band_count) begin
        g = grade_one(chan[c], chan_grade[c]);
        chan[c] = g[7:0];
        o.clip[c] = g[8];
      end
    end
    o.red = chan[0];
    o.green = chan[1];
    o.blue = chan[2];
    o.alpha = px[31:24];
    return o;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: grade_on = val[0];
      CFG_BANDS: band_count = val[1:0];
      CFG_RED: chan_grade[0] = val;
      CFG_GREEN: chan_grade[1] = val;
      CFG_BLUE: chan_grade[2] = val;
      default: ;
    endcase
  endtask

  // Drop the input, drain every pending pixel, then let the pipeline settle.
  task automatic settle;
    in_tvalid <= 1'b0;
    while (graded_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Offer one beat and hold it until taken; valid stays up for the next beat.
  task automatic send_pixel(input logic [31:0] px);
    int gap;
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    graded_queue.push_back(grade_pixel(px));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_grade();
    logic [47:0] g;
    g[15:0] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(8000, 24000));
    g[31:16] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    case ($urandom_range(0, 5))
      0: g[47:32] = 0;
      1: g[47:32] = POWER_ONE;
      2: g[47:32] = 16'($urandom);
      default: g[47:32] = 16'($urandom_range(1200, 12000));
    endcase
    return g;
  endfunction

  task automatic test_passthrough;
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8040_2010);
    settle();
  endtask

  task automatic test_extremes;
    write_reg(CFG_ENABLE, 48'd1);
    write_reg(CFG_BANDS, 48'd3);
    write_reg(CFG_RED, {16'h1800, 16'h0000, 16'h4000});   // power 1.5
    write_reg(CFG_GREEN, {16'h0000, 16'h2000, 16'hFFFF}); // power 0
    write_reg(CFG_BLUE, {16'hFFFF, 16'h8000, 16'h0000});  // negative sum
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h55AA_0180);
    send_pixel(32'h7F01_FE80);
    settle();
    write_reg(CFG_RED, {16'h0800, 16'h7FFF, 16'hFFFF});   // large result, clip
    write_reg(CFG_GREEN, {16'hFFFF, 16'h0000, 16'h0001});
    write_reg(CFG_BLUE, {16'h1000, 16'h0000, 16'h2000});
    send_pixel(32'h00FF_FF00);
    send_pixel(32'hFF01_02FF);
    send_pixel(32'h1080_4020);
    settle();
    for (int b = 0; b < 4; b++) begin
      write_reg(CFG_BANDS, 48'(b));
      send_pixel(32'hFFC0_80FF);
      send_pixel(32'h0001_407F);
      settle();
    end
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(CFG_ENABLE, 48'($urandom_range(0, 5) != 0));
      write_reg(CFG_BANDS, 48'($urandom_range(0, 3)));
      write_reg(CFG_RED, rand_grade());
      write_reg(CFG_GREEN, rand_grade());
      write_reg(CFG_BLUE, rand_grade());
      for (int i = 0; i < per_phase; i++) send_pixel($urandom);
      settle();
    end
  endtask

  // Hold the output off while pixels keep coming, so the pipeline fills.
  task automatic test_backpressure;
    -> long_hold_ev;
    for (int i = 0; i < 120; i++) send_pixel($urandom);
    settle();
  endtask

  // Count out the long receiver hold.
  always begin
    @(long_hold_ev);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      hold_off <= $urandom_range(0, 13);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[34:0];
      if (graded_queue.size() == 0) begin
        $error("unexpected beat %h", out_tdata);
        failures++;
      end else begin
        want = graded_queue.pop_front();
        if (got.red !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, got.red);
          failures++;
        end
        if (got.green !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, got.green);
          failures++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, got.blue);
          failures++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha_out expected %0d got %0d", want.alpha, got.alpha);
          failures++;
        end
        if (got.clip !== want.clip) begin
          $error("clip_flags expected %0d got %0d", want.clip, got.clip);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_wdata = 0;
    failures = 0;
    cycle_count = 0;
    hold_off = 0;
    long_hold = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    grade_on = 1'b0;
    band_count = 2'd3;
    for (int c = 0; c < 3; c++) chan_grade[c] = GRADE_RESET;
    exp_steps[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) exp_steps[k] = floor_sqrt(exp_steps[k-1] << 30);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_passthrough();
    test_extremes();
    test_backpressure();
    test_random(10, 100);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random(2, 50);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rsop_pkg.sv
rtl/core/rsop_lane.sv
rtl/core/rsop_merge.sv
rtl/core/rgb_slope_offset_power_grade_core.sv
bench/rgb_slope_offset_power_grade_core_test.sv
